// ----- rtl/core/sha1_stream_hasher_assert.svh -----
// ----------------------------------------------------------------------------
// SHA-1 stream hasher assertion macros
// Shared assertion forms for the hasher checker, sampled on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH

// Implication checked on every rising edge outside reset
`define SHA1SH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Signal pair that must never be high together
`define SHA1SH_ASSERT_NEVER_BOTH(name, sig_a, sig_b, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(sig_a && sig_b)) \
    else $error(msg);

`endif

// ----- rtl/core/sha1sh_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Transfer types and the fixed constants of the SHA-1 compression.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_item;
  } sha1sh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1sh_out_t;

  localparam int unsigned NumChain = 5;

  localparam logic [31:0] CHAIN_IV [NumChain] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
  };

  localparam logic [31:0] SHA1_K0 = 32'h5a82_7999;
  localparam logic [31:0] SHA1_K1 = 32'h6ed9_eba1;
  localparam logic [31:0] SHA1_K2 = 32'h8f1b_bcdc;
  localparam logic [31:0] SHA1_K3 = 32'hca62_c1d6;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd4;

endpackage

// ----- rtl/core/sha1_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Bytes are taken one per cycle while the hasher is idle and packed
// big-endian into a 16 x 32-bit block buffer memory. The 64th byte of a
// block starts a compression (a memory prime step, 80 rounds at one round
// per cycle through the single round unit, and a fold into the chaining
// words), and no further byte is taken until it has finished.
// An item marked last adds one or two such compressions (two when the
// message fill is 56 bytes or more, so the length no longer fits) and then
// offers the digest as five word transfers h0..h4; the hasher reloads its
// initial values after the fifth transfer. Padding and the length words are
// muxed in on the read side, so the buffer is never cleared or swept.
// ----------------------------------------------------------------------------
module sha1_stream_hasher
  import sha1sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sha1sh_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sha1sh_out_t out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRIME = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  // kind of block being compressed
  localparam logic [1:0] BLK_FULL  = 2'd0;  // 64 message bytes
  localparam logic [1:0] BLK_PADL  = 2'd1;  // tail, pad and length
  localparam logic [1:0] BLK_PAD   = 2'd2;  // tail and pad, no room for length
  localparam logic [1:0] BLK_LEN   = 2'd3;  // zeros and length only

  localparam logic [6:0] LAST_ROUND = 7'd79;

  logic [2:0]  state_q, state_d;
  logic [1:0]  kind_q, kind_d;
  logic        fin_q, fin_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic [60:0] count_q, count_d;
  logic [31:0] chain_q [NumChain];
  logic        chain_add, chain_init;

  logic [31:0] acc_q, acc_d;
  logic [31:0] vars_q [NumChain];
  logic [31:0] vars_d [NumChain];
  logic [31:0] win_q [16];
  logic [31:0] win_d [16];

  logic [31:0] buf_mem [16];
  logic [31:0] rdata_q;
  logic        mem_we;
  logic [3:0]  mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  logic        in_xfer, out_xfer;
  logic [5:0]  pos;
  logic [60:0] count_inc;
  logic [31:0] pad_word, src_word, wt, f, k, tmp;
  logic [31:0] len_hi, len_lo;
  logic [3:0]  ti, fw;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_xfer   = out_valid_o && out_ready_i;

  assign pos       = count_q[5:0];
  assign count_inc = count_q + 61'd1;
  assign len_hi    = count_q[60:29];
  assign len_lo    = {count_q[28:0], 3'b000};
  assign ti        = rnd_q[3:0];
  assign fw        = count_q[5:2];

  // Byte packing: lanes fill msb first, a word goes to memory on its fourth byte
  always_comb begin
    acc_d = acc_q;
    case (pos[1:0])
      2'd0:    acc_d[31:24] = in_data_i.data_byte;
      2'd1:    acc_d[23:16] = in_data_i.data_byte;
      2'd2:    acc_d[15:8]  = in_data_i.data_byte;
      default: acc_d[7:0]   = in_data_i.data_byte;
    endcase
  end

  assign mem_we    = in_xfer && in_data_i.byte_valid && (pos[1:0] == 2'd3);
  assign mem_waddr = pos[5:2];
  assign mem_wdata = {acc_q[31:8], in_data_i.data_byte};
  assign mem_raddr = (state_q == ST_PRIME) ? 4'd0 : ti + 4'd1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      buf_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= buf_mem[mem_raddr];
  end

  // Partial word of the tail followed by the pad byte
  always_comb begin
    case (count_q[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc_q[31:24], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc_q[31:16], PAD_BYTE, 8'h0};
      default: pad_word = {acc_q[31:8], PAD_BYTE};
    endcase
  end

  // Word fed to the first sixteen rounds
  always_comb begin
    src_word = 32'h0;
    case (kind_q)
      BLK_FULL: src_word = rdata_q;
      BLK_PADL, BLK_PAD: begin
        if (ti < fw) begin
          src_word = rdata_q;
        end else if (ti == fw) begin
          src_word = pad_word;
        end else if (kind_q == BLK_PADL && ti == 4'd14) begin
          src_word = len_hi;
        end else if (kind_q == BLK_PADL && ti == 4'd15) begin
          src_word = len_lo;
        end
      end
      default: begin
        if (ti == 4'd14) begin
          src_word = len_hi;
        end else if (ti == 4'd15) begin
          src_word = len_lo;
        end
      end
    endcase
  end

  // One round per cycle
  always_comb begin
    logic [31:0] x;
    x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    wt = (rnd_q < 7'd16) ? src_word : {x[30:0], x[31]};

    if (rnd_q inside {[7'd0:7'd19]}) begin
      f = vars_q[3] ^ (vars_q[1] & (vars_q[2] ^ vars_q[3]));
      k = SHA1_K0;
    end else if (rnd_q inside {[7'd20:7'd39]}) begin
      f = vars_q[1] ^ vars_q[2] ^ vars_q[3];
      k = SHA1_K1;
    end else if (rnd_q inside {[7'd40:7'd59]}) begin
      f = (vars_q[1] & vars_q[2]) | (vars_q[3] & (vars_q[1] | vars_q[2]));
      k = SHA1_K2;
    end else begin
      f = vars_q[1] ^ vars_q[2] ^ vars_q[3];
      k = SHA1_K3;
    end

    tmp = {vars_q[0][26:0], vars_q[0][31:27]} + f + vars_q[4] + k + wt;

    for (int i = 0; i < 15; i++) begin
      win_d[i] = win_q[i + 1];
    end
    win_d[15] = wt;

    vars_d[0] = tmp;
    vars_d[1] = vars_q[0];
    vars_d[2] = {vars_q[1][1:0], vars_q[1][31:2]};
    vars_d[3] = vars_q[2];
    vars_d[4] = vars_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.byte_valid) begin
      acc_q <= acc_d;
    end
    if (state_q == ST_PRIME) begin
      for (int i = 0; i < NumChain; i++) begin
        vars_q[i] <= chain_q[i];
      end
    end else if (state_q == ST_ROUND) begin
      vars_q <= vars_d;
      win_q  <= win_d;
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    fin_d      = fin_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    count_d    = count_q;
    chain_add  = 1'b0;
    chain_init = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.byte_valid) begin
            count_d = count_inc;
          end
          if (in_data_i.byte_valid && pos == 6'd63) begin
            kind_d  = BLK_FULL;
            fin_d   = in_data_i.last_item;
            state_d = ST_PRIME;
          end else if (in_data_i.last_item) begin
            kind_d  = (count_d[5:3] == 3'b111) ? BLK_PAD : BLK_PADL;
            fin_d   = 1'b1;
            state_d = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        rnd_d   = 7'd0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_add = 1'b1;
        case (kind_q)
          BLK_FULL: begin
            if (fin_q) begin
              kind_d  = (count_q[5:3] == 3'b111) ? BLK_PAD : BLK_PADL;
              state_d = ST_PRIME;
            end else begin
              state_d = ST_IDLE;
            end
          end
          BLK_PAD: begin
            kind_d  = BLK_LEN;
            state_d = ST_PRIME;
          end
          default: begin
            idx_d   = 3'd0;
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (idx_q == LAST_WORD_IDX) begin
            chain_init = 1'b1;
            count_d    = 61'd0;
            fin_d      = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= BLK_FULL;
      fin_q   <= 1'b0;
      rnd_q   <= 7'd0;
      idx_q   <= 3'd0;
      count_q <= 61'd0;
      for (int i = 0; i < NumChain; i++) begin
        chain_q[i] <= CHAIN_IV[i];
      end
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      fin_q   <= fin_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      for (int i = 0; i < NumChain; i++) begin
        if (chain_init) begin
          chain_q[i] <= CHAIN_IV[i];
        end else if (chain_add) begin
          chain_q[i] <= chain_q[i] + vars_q[i];
        end
      end
    end
  end

  assign out_data_o.digest_word = chain_q[idx_q];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == LAST_WORD_IDX);

endmodule

// ----- rtl/core/sha1sh_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-1 stream hasher checker
// Port-level checks on the hasher, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "sha1_stream_hasher_assert.svh"

module sha1sh_checker
  import sha1sh_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input sha1sh_in_t  in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input sha1sh_out_t out_data_o
);

  // a stalled digest word holds
  `SHA1SH_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "digest word dropped or changed while stalled")

  // no input is taken while the digest is on offer
  `SHA1SH_ASSERT_NEVER_BOTH(a_busy_emit, in_ready_o, out_valid_o, "input taken during digest output")

  // words advance by one until the fifth
  `SHA1SH_ASSERT(a_word_seq, out_valid_o && out_ready_i && !out_data_o.last_word |=> out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1, "digest word order broken")

  `SHA1SH_ASSERT(a_last_flag, out_valid_o |-> out_data_o.last_word == (out_data_o.word_index == LAST_WORD_IDX), "last word flag mismatch")

  // a finishing item starts compression
  `SHA1SH_ASSERT(a_fin_busy, in_valid_i && in_ready_o && in_data_i.last_item |=> !in_ready_o, "hasher ready right after last item")

endmodule

bind sha1_stream_hasher sha1sh_checker u_sha1sh_checker (.*);
